/* rtl/rssh_pkg.sv */
package rssh_pkg;

   localparam int GROUPS  = 8;
   localparam int BINS    = 256;
   localparam int CNT_W   = 16;
   localparam int HIST_W  = 40;
   localparam int POS_W   = 32;
   localparam int GRP_W   = (GROUPS > 1) ? $clog2(GROUPS) : 1;
   localparam int BIN_W   = $clog2(BINS);
   localparam int GADDR_W = $clog2(GROUPS * BINS);
   localparam int SUM_W   = CNT_W + GRP_W;
   localparam int QDEPTH  = 2;
   localparam int QPTR_W  = 1;

   localparam logic KIND_EVENT = 1'b0;
   localparam logic KIND_QUERY = 1'b1;

   typedef struct packed {
      logic             is_query;
      logic             chrom_changed;
      logic [POS_W-1:0] chrom_first;
      logic [POS_W-1:0] chrom_last;
      logic [POS_W-1:0] start_pos;
      logic [2:0]       group_id;
      logic             group_ok;
      logic             query_combined;
      logic [2:0]       query_group;
      logic [7:0]       query_bin;
      logic             query_ok;
   } item_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_CHG_SET,
      ST_EVT,
      ST_EVT_SET,
      ST_CLOSE_INIT,
      ST_G0_RD,
      ST_G0_WR,
      ST_GB_RD,
      ST_GB_WR,
      ST_C_RD,
      ST_C_WR,
      ST_QRD,
      ST_QOUT
   } state_type;

   function automatic logic [BIN_W-1:0] bin_of(input logic [SUM_W-1:0] c);
      logic [BIN_W-1:0] b;
      if (32'(c) >= BINS) b = BIN_W'(BINS - 1);
      else b = BIN_W'(c);
      return b;
   endfunction

   function automatic logic [HIST_W-1:0] hist_add(input logic [HIST_W-1:0] h,
                                                  input logic [POS_W:0]    a);
      logic [HIST_W:0]   s;
      logic [HIST_W-1:0] r;
      s = {1'b0, h} + (HIST_W+1)'(a);
      if (s[HIST_W]) r = '1;
      else r = s[HIST_W-1:0];
      return r;
   endfunction

endpackage

/* rtl/rssh_front.sv */
module rssh_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic                req_kind,
   input  logic                req_chrom_changed,
   input  logic [31:0]         req_chrom_first,
   input  logic [31:0]         req_chrom_last,
   input  logic [31:0]         req_start_pos,
   input  logic [2:0]          req_group_id,
   input  logic                req_query_combined,
   input  logic [2:0]          req_query_group,
   input  logic [7:0]          req_query_bin,
   output logic                q_valid,
   output rssh_pkg::item_type  q_item,
   input  logic                q_pop
);
   import rssh_pkg::*;

   item_type          q_ff [QDEPTH];
   logic [QPTR_W-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [QPTR_W:0]   cnt_ff, cnt_in;
   item_type          cls;
   logic              push;

   // classify on the way in
   always_comb begin
      cls.is_query       = (req_kind == KIND_QUERY);
      cls.chrom_changed  = req_chrom_changed;
      cls.chrom_first    = req_chrom_first;
      cls.chrom_last     = req_chrom_last;
      cls.start_pos      = req_start_pos;
      cls.group_id       = req_group_id;
      cls.group_ok       = (int'(req_group_id) < GROUPS);
      cls.query_combined = req_query_combined;
      cls.query_group    = req_query_group;
      cls.query_bin      = req_query_bin;
      cls.query_ok       = (int'(req_query_bin) < BINS) &&
                           (req_query_combined || (int'(req_query_group) < GROUPS));
   end

   assign req_stall = (cnt_ff == (QPTR_W+1)'(QDEPTH));
   assign push      = req_valid && !req_stall;
   assign q_valid   = (cnt_ff != '0);
   assign q_item    = q_ff[rd_ff];

   always_comb begin
      wr_in  = push ? wr_ff + 1'b1 : wr_ff;
      rd_in  = q_pop ? rd_ff + 1'b1 : rd_ff;
      cnt_in = cnt_ff + (QPTR_W+1)'(push) - (QPTR_W+1)'(q_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) q_ff[wr_ff] <= cls;
   end

endmodule

/* rtl/rssh_back.sv */
module rssh_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                q_valid,
   input  rssh_pkg::item_type  q_item,
   output logic                q_pop,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [39:0]         rsp_bin_count
);
   import rssh_pkg::*;

   state_type          state_ff, state_in;
   item_type           item_ff;
   logic [POS_W-1:0]   cur_ff, end_ff, next_ff, gap_ff;
   logic               end_valid_ff, after_chg_ff;
   logic [CNT_W-1:0]   cnt_ff [GROUPS];
   logic [GRP_W-1:0]   g_ff;
   logic [BIN_W-1:0]   tbin_ff;
   logic [GADDR_W-1:0] clr_ff;
   logic [HIST_W-1:0]  gmem [GROUPS*BINS];
   logic [HIST_W-1:0]  cmem [BINS];
   logic [HIST_W-1:0]  grd_ff, crd_ff;
   logic               rsp_valid_ff;
   logic [HIST_W-1:0]  rsp_count_ff;

   logic [CNT_W-1:0]   cnt_g;
   logic [GADDR_W-1:0] addr0, addrb, qaddr;
   logic [SUM_W-1:0]   total;
   logic [POS_W:0]     amt0, amt1;
   logic               g_re, g_we, c_re, c_we, rsp_load, last_g, clr_done;
   logic [GADDR_W-1:0] g_addr;
   logic [BIN_W-1:0]   c_addr;
   logic [HIST_W-1:0]  g_wdata, c_wdata;

   assign cnt_g    = cnt_ff[g_ff];
   assign addr0    = GADDR_W'(g_ff) * GADDR_W'(BINS);
   assign addrb    = addr0 + GADDR_W'(bin_of(SUM_W'(cnt_g)));
   assign qaddr    = GADDR_W'(item_ff.query_group) * GADDR_W'(BINS)
                     + GADDR_W'(item_ff.query_bin);
   assign amt1     = {1'b0, gap_ff} + (POS_W+1)'(1);
   assign amt0     = (cnt_g == '0) ? amt1 : {1'b0, gap_ff};
   assign last_g   = (g_ff == GRP_W'(GROUPS - 1));
   assign clr_done = (clr_ff == GADDR_W'(GROUPS * BINS - 1));
   assign rsp_load = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      total = '0;
      for (int i = 0; i < GROUPS; i++) total = total + SUM_W'(cnt_ff[i]);
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR:      if (clr_done) state_in = ST_IDLE;
         ST_IDLE: begin
            if (q_valid) begin
               if (q_item.is_query) state_in = ST_QRD;
               else if (q_item.chrom_changed)
                  state_in = end_valid_ff ? ST_CLOSE_INIT : ST_CHG_SET;
               else state_in = ST_EVT;
            end
         end
         ST_CHG_SET:    state_in = ST_EVT;
         ST_EVT: begin
            if (item_ff.start_pos > cur_ff) state_in = ST_CLOSE_INIT;
            else state_in = ST_IDLE;
         end
         ST_EVT_SET:    state_in = ST_IDLE;
         ST_CLOSE_INIT: state_in = ST_G0_RD;
         ST_G0_RD:      state_in = ST_G0_WR;
         ST_G0_WR: begin
            if (cnt_g != '0) state_in = ST_GB_RD;
            else if (last_g) state_in = ST_C_RD;
            else state_in = ST_G0_RD;
         end
         ST_GB_RD:      state_in = ST_GB_WR;
         ST_GB_WR:      state_in = last_g ? ST_C_RD : ST_G0_RD;
         ST_C_RD:       state_in = ST_C_WR;
         ST_C_WR:       state_in = after_chg_ff ? ST_CHG_SET : ST_EVT_SET;
         ST_QRD:        state_in = ST_QOUT;
         ST_QOUT:       if (rsp_load) state_in = ST_IDLE;
         default:       state_in = ST_CLEAR;
      endcase
   end

   // outputs
   always_comb begin
      q_pop   = 1'b0;
      g_re    = 1'b0;
      g_we    = 1'b0;
      c_re    = 1'b0;
      c_we    = 1'b0;
      g_addr  = addr0;
      c_addr  = tbin_ff;
      g_wdata = '0;
      c_wdata = '0;
      case (state_ff)
         ST_CLEAR: begin
            g_we   = 1'b1;
            g_addr = clr_ff;
            c_we   = (int'(clr_ff) < BINS);
            c_addr = BIN_W'(clr_ff);
         end
         ST_IDLE:  q_pop = q_valid;
         ST_G0_RD: g_re = 1'b1;
         ST_G0_WR: begin
            g_we    = 1'b1;
            g_wdata = hist_add(grd_ff, amt0);
         end
         ST_GB_RD: begin
            g_re   = 1'b1;
            g_addr = addrb;
         end
         ST_GB_WR: begin
            g_we    = 1'b1;
            g_addr  = addrb;
            g_wdata = hist_add(grd_ff, (POS_W+1)'(1));
         end
         ST_C_RD:  c_re = 1'b1;
         ST_C_WR: begin
            c_we    = 1'b1;
            c_wdata = hist_add(crd_ff, amt1);
         end
         ST_QRD: begin
            g_re   = 1'b1;
            g_addr = qaddr;
            c_re   = 1'b1;
            c_addr = BIN_W'(item_ff.query_bin);
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (g_we) gmem[g_addr] <= g_wdata;
      if (g_re) grd_ff <= gmem[g_addr];
      if (c_we) cmem[c_addr] <= c_wdata;
      if (c_re) crd_ff <= cmem[c_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         cur_ff       <= '0;
         end_ff       <= '0;
         end_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < GROUPS; i++) cnt_ff[i] <= '0;
      end else begin
         state_ff <= state_in;
         case (state_ff)
            ST_CLEAR: clr_ff <= clr_ff + 1'b1;
            ST_IDLE: begin
               if (q_valid) begin
                  item_ff      <= q_item;
                  next_ff      <= end_ff;
                  after_chg_ff <= 1'b1;
               end
            end
            ST_CHG_SET: begin
               cur_ff       <= item_ff.chrom_first;
               end_ff       <= item_ff.chrom_last;
               end_valid_ff <= 1'b1;
               for (int i = 0; i < GROUPS; i++) cnt_ff[i] <= '0;
            end
            ST_EVT: begin
               if (item_ff.start_pos == cur_ff) begin
                  for (int i = 0; i < GROUPS; i++) begin
                     if (item_ff.group_ok && int'(item_ff.group_id) == i &&
                         cnt_ff[i] != '1)
                        cnt_ff[i] <= cnt_ff[i] + 1'b1;
                  end
               end else begin
                  next_ff      <= item_ff.start_pos;
                  after_chg_ff <= 1'b0;
               end
            end
            ST_EVT_SET: begin
               cur_ff <= item_ff.start_pos;
               for (int i = 0; i < GROUPS; i++)
                  cnt_ff[i] <= CNT_W'(item_ff.group_ok && int'(item_ff.group_id) == i);
            end
            ST_CLOSE_INIT: begin
               gap_ff  <= (next_ff > cur_ff) ? next_ff - cur_ff - 1'b1 : '0;
               tbin_ff <= bin_of(total);
               g_ff    <= '0;
            end
            ST_G0_WR: if (cnt_g == '0 && !last_g) g_ff <= g_ff + 1'b1;
            ST_GB_WR: if (!last_g) g_ff <= g_ff + 1'b1;
            ST_QOUT: begin
               if (rsp_load) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_count_ff <= !item_ff.query_ok ? '0 :
                                  item_ff.query_combined ? crd_ff : grd_ff;
               end
            end
            default: ;
         endcase
         if (rsp_valid_ff && !rsp_stall && !(state_ff == ST_QOUT))
            rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_bin_count = rsp_count_ff;

`ifndef SYNTH
   a_pop_idle: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> (state_ff == ST_IDLE && !$past(reset)))
      else $error("item taken outside idle");
   a_rsp_from_query: assert property (@(posedge clock) disable iff (reset)
      (!rsp_valid_ff ##1 rsp_valid_ff) |-> $past(state_ff == ST_QOUT))
      else $error("result without readout");
   a_close_walk: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_GB_WR && !last_g) |=> (state_ff == ST_G0_RD && g_ff != '0))
      else $error("group walk skipped");
   a_no_write_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE || state_ff == ST_QOUT) |-> (!g_we && !c_we))
      else $error("histogram written while idle");
`endif

endmodule

/* rtl/read_start_site_histogram.sv */
// Read start site histogram.
// req_* carries one item per handshake (req_valid high, req_stall low at a
// rising edge). An alignment start item (req_kind 0) updates the site counts
// and gives no result. A readout item (req_kind 1) returns one rsp_bin_count
// on the rsp_* channel.
// Items enter a two-entry queue; the back end works on one item at a time.
// Work per item, after it leaves the queue:
//   readout: the histogram is read, then rsp_valid rises (if the output
//   register is free).
//   event closing a site: each group takes a read-modify-write of its bin
//   zero and, if its count is nonzero, one of its count bin, all on the single
//   histogram port.
//   chromosome change closing the old chromosome adds one such close.
// Reset: clears site counts and position state, then sweeps both histogram
// memories to zero, one entry a cycle across GROUPS*BINS (2048) entries; no
// item is taken during the sweep (req_stall rises once the queue fills).
// A stalled result holds in the output register; later events are processed,
// but the back end waits on the next readout, taking nothing, until it drains.
module read_start_site_histogram (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_kind,
   input  logic        req_chrom_changed,
   input  logic [31:0] req_chrom_first,
   input  logic [31:0] req_chrom_last,
   input  logic [31:0] req_start_pos,
   input  logic [2:0]  req_group_id,
   input  logic        req_query_combined,
   input  logic [2:0]  req_query_group,
   input  logic [7:0]  req_query_bin,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [39:0] rsp_bin_count
);
   import rssh_pkg::*;

   item_type q_item;
   logic     q_valid, q_pop;

   rssh_front u_front (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_kind           (req_kind),
      .req_chrom_changed  (req_chrom_changed),
      .req_chrom_first    (req_chrom_first),
      .req_chrom_last     (req_chrom_last),
      .req_start_pos      (req_start_pos),
      .req_group_id       (req_group_id),
      .req_query_combined (req_query_combined),
      .req_query_group    (req_query_group),
      .req_query_bin      (req_query_bin),
      .q_valid            (q_valid),
      .q_item             (q_item),
      .q_pop              (q_pop)
   );

   rssh_back u_back (
      .clock         (clock),
      .reset         (reset),
      .q_valid       (q_valid),
      .q_item        (q_item),
      .q_pop         (q_pop),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_bin_count (rsp_bin_count)
   );

endmodule

/* tb/read_start_site_histogram_tb.sv */
module read_start_site_histogram_tb;
   import rssh_pkg::*;

   typedef struct {
      logic        kind;
      logic        chg;
      logic [31:0] first;
      logic [31:0] last;
      logic [31:0] pos;
      logic [2:0]  grp;
      logic        qcomb;
      logic [2:0]  qgrp;
      logic [7:0]  qbin;
   } req_item_t;

   logic        clock = 0;
   logic        reset = 1;
   logic        req_valid = 0;
   logic        req_stall;
   logic        req_kind = 0;
   logic        req_chrom_changed = 0;
   logic [31:0] req_chrom_first = 0;
   logic [31:0] req_chrom_last = 0;
   logic [31:0] req_start_pos = 0;
   logic [2:0]  req_group_id = 0;
   logic        req_query_combined = 0;
   logic [2:0]  req_query_group = 0;
   logic [7:0]  req_query_bin = 0;
   logic        rsp_valid;
   logic        rsp_stall = 0;
   logic [39:0] rsp_bin_count;

   read_start_site_histogram DUT (.*);

   always #5 clock = ~clock;

   req_item_t       pending_items[$];
   logic [39:0]     expected_counts[$];
   int              send_idle_pct = 0;
   int              stall_pct = 0;
   bit              hold_rsp = 0;
   int              mismatches = 0;
   int              cycles = 0;
   int              accepted = 0;

   // shadow state of the block
   logic [15:0] site_cnt[GROUPS];
   logic [39:0] grp_hist[GROUPS][BINS];
   logic [39:0] comb_hist[BINS];
   logic [31:0] cur_site;
   logic [31:0] chr_end;
   bit          chr_valid;

   function automatic logic [39:0] sat_add(logic [39:0] h, logic [32:0] a);
      logic [40:0] s;
      s = {1'b0, h} + 41'(a);
      return s[40] ? 40'hFF_FFFF_FFFF : s[39:0];
   endfunction

   function automatic int bin_index(logic [31:0] c);
      return (c >= BINS) ? BINS - 1 : int'(c);
   endfunction

   function automatic void close_site(logic [31:0] nxt);
      logic [32:0] gap;
      logic [31:0] total;
      int b;
      gap = (nxt > cur_site) ? 33'(nxt - cur_site - 1) : 33'd0;
      total = 0;
      for (int g = 0; g < GROUPS; g++) begin
         total += 32'(site_cnt[g]);
         b = bin_index(32'(site_cnt[g]));
         grp_hist[g][b] = sat_add(grp_hist[g][b], 33'd1);
         grp_hist[g][0] = sat_add(grp_hist[g][0], gap);
      end
      b = bin_index(total);
      comb_hist[b] = sat_add(comb_hist[b], 33'd1);
      comb_hist[b] = sat_add(comb_hist[b], gap);
   endfunction

   function automatic void predict_item(req_item_t it);
      if (it.kind == KIND_QUERY) begin
         expected_counts.push_back(it.qcomb ? comb_hist[it.qbin]
                                            : grp_hist[it.qgrp][it.qbin]);
         return;
      end
      if (it.chg) begin
         if (chr_valid) close_site(chr_end);
         cur_site = it.first;
         chr_end = it.last;
         chr_valid = 1;
         for (int g = 0; g < GROUPS; g++) site_cnt[g] = 0;
      end
      if (it.pos == cur_site) begin
         if (site_cnt[it.grp] != 16'hFFFF) site_cnt[it.grp]++;
      end else if (it.pos > cur_site) begin
         close_site(it.pos);
         cur_site = it.pos;
         for (int g = 0; g < GROUPS; g++) site_cnt[g] = 0;
         site_cnt[it.grp] = 1;
      end
   endfunction

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 0;
      end else begin
         if (req_valid && !req_stall) begin
            predict_item(pending_items.pop_front());
            accepted++;
         end
         if (!(req_valid && req_stall)) begin
            // the accepted item is already popped, so the next one is at the front
            if (pending_items.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
               req_item_t it;
               it = pending_items[0];
               req_valid <= 1;
               req_kind <= it.kind;
               req_chrom_changed <= it.chg;
               req_chrom_first <= it.first;
               req_chrom_last <= it.last;
               req_start_pos <= it.pos;
               req_group_id <= it.grp;
               req_query_combined <= it.qcomb;
               req_query_group <= it.qgrp;
               req_query_bin <= it.qbin;
            end else begin
               req_valid <= 0;
            end
         end
      end
   end

   // monitor and receiver stall
   always @(posedge clock) begin
      cycles++;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_counts.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) $display("unexpected result %h", rsp_bin_count);
            end else begin
               logic [39:0] exp_c;
               exp_c = expected_counts.pop_front();
               if (exp_c !== rsp_bin_count) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("bin_count mismatch: expected %h got %h", exp_c, rsp_bin_count);
               end
            end
         end
         rsp_stall <= hold_rsp || ($urandom_range(99) < stall_pct);
      end
      if (cycles > 3000000) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   function automatic req_item_t event_item(bit chg, logic [31:0] first, logic [31:0] last,
                                            logic [31:0] pos, logic [2:0] grp);
      req_item_t it;
      it = '{default: '0};
      it.kind = KIND_EVENT;
      it.chg = chg; it.first = first; it.last = last; it.pos = pos; it.grp = grp;
      return it;
   endfunction

   function automatic req_item_t query_item(bit comb, logic [2:0] grp, logic [7:0] bin);
      req_item_t it;
      it.kind = KIND_QUERY;
      it.chg = 1'($urandom); it.first = $urandom; it.last = $urandom;
      it.pos = $urandom; it.grp = 3'($urandom);
      it.qcomb = comb; it.qgrp = grp; it.qbin = bin;
      return it;
   endfunction

   task automatic drain();
      while (pending_items.size() != 0 || req_valid || expected_counts.size() != 0)
         @(posedge clock);
      repeat (60) @(posedge clock);
   endtask

   // mostly sorted stream: a chromosome, then forward walk with repeats, some backward steps, jumps and changes
   task automatic add_chromosome(int n_events);
      logic [31:0] base, pos, span;
      span = (($urandom_range(9) == 0) ? $urandom : $urandom_range(300, 10));
      base = (($urandom_range(7) == 0) ? $urandom : $urandom_range(100000));
      pending_items.push_back(event_item(1, base, base + span, base, 3'($urandom)));
      pos = base;
      for (int i = 0; i < n_events; i++) begin
         case ($urandom_range(9))
            0, 1, 2, 3: ;
            4, 5, 6:    pos += $urandom_range(3, 1);
            7:          pos += $urandom_range(40, 4);
            8:          pos -= $urandom_range(2, 1);
            default:    pos = $urandom;
         endcase
         if ($urandom_range(19) == 0)
            pending_items.push_back(event_item(1, $urandom, $urandom, $urandom,
                                               3'($urandom)));
         else
            pending_items.push_back(event_item(0, $urandom, $urandom, pos,
                                               ($urandom_range(3) == 0)
                                                  ? 3'($urandom_range(7))
                                                  : 3'($urandom_range(2))));
         if ($urandom_range(5) == 0) add_query();
      end
   endtask

   task automatic add_query();
      pending_items.push_back(query_item(1'($urandom), 3'($urandom),
                                         ($urandom_range(2) == 0)
                                            ? 8'($urandom)
                                            : 8'($urandom_range(4))));
   endtask

   initial begin
      for (int g = 0; g < GROUPS; g++) begin
         site_cnt[g] = 0;
         for (int b = 0; b < BINS; b++) grp_hist[g][b] = 0;
      end
      for (int b = 0; b < BINS; b++) comb_hist[b] = 0;
      cur_site = 0; chr_end = 0; chr_valid = 0;
      repeat (6) @(posedge clock);
      reset <= 0;

      // directed: extremes, events behind the site, huge gaps
      pending_items.push_back(query_item(1, 0, 0));
      pending_items.push_back(event_item(0, 0, 0, 0, 7));
      pending_items.push_back(event_item(0, 0, 0, 5, 0));
      pending_items.push_back(event_item(0, 0, 0, 5, 0));
      pending_items.push_back(event_item(0, 0, 0, 3, 2));
      pending_items.push_back(event_item(1, 32'hFFFF_FFF0, 32'hFFFF_FFFF, 32'hFFFF_FFF0, 4));
      pending_items.push_back(event_item(0, 0, 0, 32'hFFFF_FFFF, 7));
      pending_items.push_back(event_item(1, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1));
      pending_items.push_back(event_item(1, 10, 0, 2, 3));
      pending_items.push_back(event_item(1, 20, 30, 25, 6));
      pending_items.push_back(query_item(1, 0, 0));
      pending_items.push_back(query_item(1, 0, 1));
      pending_items.push_back(query_item(0, 0, 0));
      pending_items.push_back(query_item(0, 7, 255));
      pending_items.push_back(query_item(0, 4, 1));
      pending_items.push_back(query_item(1, 7, 255));
      pending_items.push_back(query_item(0, 3, 0));
      drain();

      // more than BINS starts on one site drives the top bin
      pending_items.push_back(event_item(1, 1000, 2000, 1000, 0));
      for (int i = 0; i < 300; i++)
         pending_items.push_back(event_item(0, 0, 0, 1000, 3'(i % 2)));
      pending_items.push_back(event_item(0, 0, 0, 1001, 0));
      pending_items.push_back(query_item(1, 0, 255));
      pending_items.push_back(query_item(0, 0, 150));
      drain();

      for (int phase = 0; phase < 4; phase++) begin
         send_idle_pct = (phase == 1 || phase == 3) ? (phase == 1 ? 77 : 24) : 0;
         stall_pct = (phase == 2) ? 77 : (phase == 3 ? 24 : 0);
         while (pending_items.size() < 380) add_chromosome($urandom_range(40, 5));
         for (int b = 0; b < 6; b++) add_query();
         if (phase == 0) begin
            // long receiver hold-off while items keep coming
            fork
               begin
                  hold_rsp = 1;
                  repeat (400) @(posedge clock);
                  hold_rsp = 0;
               end
            join_none
         end
         drain();
      end

      if (mismatches == 0 && expected_counts.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end
endmodule
